>>> rtl/pedq_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pedq_pkg
// Shared types and constants for the priority event queue dispatcher.
// ----------------------------------------------------------------------------
package pedq_pkg;

  localparam int PORTS_DEF  = 4096;
  localparam int QUEUES_DEF = 16;
  localparam int PORT_W     = 12;
  localparam int LINK_W     = 12;
  localparam int PRIO_W     = 4;
  localparam int FUNC_W     = 3;

  typedef enum logic [FUNC_W-1:0] {
    F_SET_PEND  = 3'd0,
    F_CLR_PEND  = 3'd1,
    F_TSET_MASK = 3'd2,
    F_UNMASK    = 3'd3,
    F_QUERY     = 3'd4,
    F_WRITE     = 3'd5,
    F_POST      = 3'd6,
    F_CONSUME   = 3'd7
  } func_t;

  typedef enum logic [1:0] {
    S_CLEAR,
    S_IDLE,
    S_EXEC
  } state_t;

  typedef enum logic [1:0] {
    C_NONE,
    C_EMPTY,
    C_HIT
  } cons_t;

  typedef struct packed {
    logic              pending;
    logic              masked;
    logic              linked;
    logic [LINK_W-1:0] link;
  } ev_word_t;

  localparam ev_word_t WORD_RESET = '{pending: 1'b0, masked: 1'b1,
                                      linked: 1'b0, link: '0};

endpackage

>>> rtl/pedq_event_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pedq_event_ram
// Event word store: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module pedq_event_ram #(
  parameter int PORTS = pedq_pkg::PORTS_DEF,
  parameter int AW    = $clog2(PORTS)
) (
  input  logic               clk,
  input  logic               we,
  input  logic [AW-1:0]      waddr,
  input  pedq_pkg::ev_word_t wdata,
  input  logic [AW-1:0]      raddr,
  output pedq_pkg::ev_word_t rdata
);

  pedq_pkg::ev_word_t mem [PORTS];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

>>> rtl/priority_event_queue_dispatcher.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// priority_event_queue_dispatcher
// Event word store with priority queues: pending/mask operations, word and
// queue writes, and consume of the lowest ready priority.
//
//   channel   | handshake          | signals
//   ----------+--------------------+----------------------------------------
//   request   | start / busy       | func port prio word_pending word_masked
//             |                    | word_linked word_link
//   result    | done (one cycle)   | out_port flag notify_unmask
//             |                    | queue_emptied none_ready
//
// Every request reads the event word from the RAM in the accept cycle; a
// changed word is written back in the execute cycle. done is high in the
// cycle after execute, and a new request may be accepted in that cycle.
// After reset the RAM is swept to its reset word with busy high.
// The result side cannot stall; each result is valid for exactly one cycle.
// ----------------------------------------------------------------------------
module priority_event_queue_dispatcher #(
  parameter int PORTS  = pedq_pkg::PORTS_DEF,
  parameter int QUEUES = pedq_pkg::QUEUES_DEF
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  output logic                        busy,
  input  logic [pedq_pkg::FUNC_W-1:0] func,
  input  logic [pedq_pkg::PORT_W-1:0] port,
  input  logic [pedq_pkg::PRIO_W-1:0] prio,
  input  logic                        word_pending,
  input  logic                        word_masked,
  input  logic                        word_linked,
  input  logic [pedq_pkg::LINK_W-1:0] word_link,
  output logic                        done,
  output logic [pedq_pkg::PORT_W-1:0] out_port,
  output logic                        flag,
  output logic                        notify_unmask,
  output logic                        queue_emptied,
  output logic                        none_ready
);

  localparam int AW = $clog2(PORTS);
  localparam int QW = $clog2(QUEUES);

  pedq_pkg::state_t state, state_next;

  logic [AW-1:0] clr_addr;
  logic          clr_last;

  logic                        op_valid;
  pedq_pkg::func_t             op_func;
  logic [pedq_pkg::PORT_W-1:0] op_port;
  logic [pedq_pkg::PRIO_W-1:0] op_prio;
  pedq_pkg::ev_word_t          op_word;
  pedq_pkg::cons_t             op_cons;
  logic [QW-1:0]               op_q;
  logic [pedq_pkg::LINK_W-1:0] op_head;

  logic [QUEUES-1:0]           ready;
  logic [pedq_pkg::LINK_W-1:0] local_head  [QUEUES];
  logic [pedq_pkg::LINK_W-1:0] shared_head [QUEUES];

  logic                        accept;
  logic [QW-1:0]               sel_q;
  logic                        any_ready;
  logic [pedq_pkg::LINK_W-1:0] sel_head;
  logic                        head_ok;
  logic                        port_ok;

  logic               mem_we;
  logic [AW-1:0]      mem_waddr;
  pedq_pkg::ev_word_t mem_wdata;
  logic [AW-1:0]      mem_raddr;
  pedq_pkg::ev_word_t mem_rdata;

  logic                        ex_we;
  pedq_pkg::ev_word_t          ex_word;
  logic [pedq_pkg::PORT_W-1:0] ex_port;
  logic                        ex_flag;
  logic                        ex_notify;
  logic                        ex_emptied;
  logic                        ex_none;
  logic                        post_ok;

  assign accept   = start && !busy;
  assign clr_last = (clr_addr == AW'(PORTS - 1));
  assign port_ok  = (32'(port) < PORTS);
  assign post_ok  = (32'(op_prio) < QUEUES);

  // lowest ready priority and its head
  always_comb begin
    sel_q     = '0;
    any_ready = 1'b0;
    for (int i = 0; i < QUEUES; i++) begin
      if (ready[i] && !any_ready) begin
        sel_q     = QW'(i);
        any_ready = 1'b1;
      end
    end
    sel_head = (local_head[sel_q] != '0) ? local_head[sel_q] : shared_head[sel_q];
    head_ok  = (sel_head != '0) && (32'(sel_head) < PORTS);
  end

  // next state
  always_comb begin
    state_next = state;
    case (state)
      pedq_pkg::S_CLEAR: if (clr_last) state_next = pedq_pkg::S_IDLE;
      pedq_pkg::S_IDLE:  if (start)    state_next = pedq_pkg::S_EXEC;
      pedq_pkg::S_EXEC:  state_next = pedq_pkg::S_IDLE;
      default:           state_next = pedq_pkg::S_CLEAR;
    endcase
  end

  // state outputs and RAM control
  always_comb begin
    busy      = 1'b1;
    mem_we    = 1'b0;
    mem_waddr = clr_addr;
    mem_wdata = pedq_pkg::WORD_RESET;
    case (state)
      pedq_pkg::S_CLEAR: begin
        mem_we = 1'b1;
      end
      pedq_pkg::S_IDLE: begin
        busy = 1'b0;
      end
      pedq_pkg::S_EXEC: begin
        mem_we    = ex_we;
        mem_waddr = (op_func == pedq_pkg::F_CONSUME) ? AW'(op_head) : AW'(op_port);
        mem_wdata = ex_word;
      end
      default: begin
        busy = 1'b1;
      end
    endcase
    mem_raddr = (pedq_pkg::func_t'(func) == pedq_pkg::F_CONSUME) ? AW'(sel_head)
                                                                 : AW'(port);
  end

  // execute: modify the word read in the accept cycle
  always_comb begin
    ex_word    = mem_rdata;
    ex_we      = op_valid;
    ex_port    = op_port;
    ex_flag    = 1'b0;
    ex_notify  = 1'b0;
    ex_emptied = 1'b0;
    ex_none    = 1'b0;
    case (op_func)
      pedq_pkg::F_SET_PEND:  ex_word.pending = 1'b1;
      pedq_pkg::F_CLR_PEND:  ex_word.pending = 1'b0;
      pedq_pkg::F_TSET_MASK: begin
        ex_flag        = op_valid && mem_rdata.masked;
        ex_word.masked = 1'b1;
      end
      pedq_pkg::F_UNMASK: begin
        ex_word.masked = 1'b0;
        ex_notify      = op_valid && mem_rdata.pending;
      end
      pedq_pkg::F_QUERY: ex_flag = op_valid && mem_rdata.pending;
      pedq_pkg::F_WRITE: ex_word = op_word;
      pedq_pkg::F_POST:  ex_we   = 1'b0;
      pedq_pkg::F_CONSUME: begin
        ex_we          = (op_cons == pedq_pkg::C_HIT);
        ex_word.linked = 1'b0;
        ex_word.link   = '0;
        ex_port        = '0;
        case (op_cons)
          pedq_pkg::C_NONE:  ex_none    = 1'b1;
          pedq_pkg::C_EMPTY: ex_emptied = 1'b1;
          pedq_pkg::C_HIT: begin
            ex_port    = op_head;
            ex_emptied = (mem_rdata.link == '0);
            ex_flag    = mem_rdata.pending && !mem_rdata.masked;
          end
          default: ex_none = 1'b1;
        endcase
      end
      default: ex_we = 1'b0;
    endcase
  end

  pedq_event_ram #(
    .PORTS (PORTS),
    .AW    (AW)
  ) u_ram (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= pedq_pkg::S_CLEAR;
      clr_addr <= '0;
    end else begin
      state <= state_next;
      if (state == pedq_pkg::S_CLEAR) begin
        clr_addr <= clr_addr + AW'(1);
      end
    end
  end

  // request capture
  always_ff @(posedge clk) begin
    if (accept) begin
      op_valid        <= port_ok;
      op_func         <= pedq_pkg::func_t'(func);
      op_port         <= port;
      op_prio         <= prio;
      op_word.pending <= word_pending;
      op_word.masked  <= word_masked;
      op_word.linked  <= word_linked;
      op_word.link    <= word_link;
      op_q            <= sel_q;
      op_head         <= sel_head;
      if (!any_ready) begin
        op_cons <= pedq_pkg::C_NONE;
      end else if (!head_ok) begin
        op_cons <= pedq_pkg::C_EMPTY;
      end else begin
        op_cons <= pedq_pkg::C_HIT;
      end
    end
  end

  // queue heads and ready mask
  always_ff @(posedge clk) begin
    if (rst) begin
      ready <= '0;
      for (int i = 0; i < QUEUES; i++) begin
        local_head[i]  <= '0;
        shared_head[i] <= '0;
      end
    end else if (state == pedq_pkg::S_EXEC) begin
      if (op_func == pedq_pkg::F_POST && post_ok) begin
        shared_head[QW'(op_prio)] <= op_port;
        ready[QW'(op_prio)]       <= 1'b1;
      end
      if (op_func == pedq_pkg::F_CONSUME && op_cons == pedq_pkg::C_EMPTY) begin
        ready[op_q]      <= 1'b0;
        local_head[op_q] <= '0;
      end
      if (op_func == pedq_pkg::F_CONSUME && op_cons == pedq_pkg::C_HIT) begin
        local_head[op_q] <= mem_rdata.link;
        if (mem_rdata.link == '0) begin
          ready[op_q] <= 1'b0;
        end
      end
    end
  end

  // result registers
  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= (state == pedq_pkg::S_EXEC);
    end
  end

  always_ff @(posedge clk) begin
    if (state == pedq_pkg::S_EXEC) begin
      out_port      <= ex_port;
      flag          <= ex_flag;
      notify_unmask <= ex_notify;
      queue_emptied <= ex_emptied;
      none_ready    <= ex_none;
    end
  end

  a_done_single: assert property (@(posedge clk) disable iff (rst)
    done |=> !done)
    else $error("result strobe held for two cycles");

  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    done |-> !busy)
    else $error("result raised while a request is still in flight");

  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> (busy && !done))
    else $error("request accepted without entering execute");

  a_none_clean: assert property (@(posedge clk) disable iff (rst)
    (done && none_ready) |-> (out_port == '0 && !queue_emptied && !flag))
    else $error("empty consume returned a port or emptied a queue");

endmodule
